// ===== sv/tbpf_pkg.sv =====
`default_nettype none

package tbpf_pkg;

  localparam int unsigned VRAM_AW    = 13;
  localparam int unsigned VRAM_DEPTH = 1 << VRAM_AW;
  localparam int unsigned CFG_IW     = 2;
  localparam int unsigned CFG_DW     = 8;

  localparam logic [CFG_IW-1:0] CFG_MAP_SELECT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DATA_SELECT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PALETTE     = 2'd2;

  localparam logic       MAP_SELECT_RST  = 1'b0;
  localparam logic       DATA_SELECT_RST = 1'b1;
  localparam logic [7:0] PALETTE_RST     = 8'd252;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Both tile maps sit in the top quarter of video memory.
  localparam logic [1:0] MAP_AREA_TOP     = 2'b11;
  // Tile index of the 0x9000 area in units of one 16-byte tile.
  localparam logic [8:0] SIGNED_TILE_BASE = 9'h100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_ROW
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [12:0] mem_offset;
    logic [7:0] mem_byte;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic [1:0] color_index;
    logic [1:0] shade;
  } out_beat_t;

  typedef struct packed {
    logic               we;
    logic [VRAM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re_a;
    logic [VRAM_AW-1:0] addr_a;
    logic               re_b;
    logic [VRAM_AW-1:0] addr_b;
  } vram_req_t;

endpackage

`default_nettype wire

// ===== sv/tbpf_vram.sv =====
`default_nettype none

module tbpf_vram
  import tbpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire vram_req_t req_i,
  output logic [7:0]     rd_a_o,
  output logic [7:0]     rd_b_o
);

  logic [7:0] mem [VRAM_DEPTH];
  logic [7:0] rd_a_q;
  logic [7:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read data holds until the next read on the same port.
  always_ff @(posedge clk_i) begin
    if (req_i.re_a) begin
      rd_a_q <= mem[req_i.addr_a];
    end
    if (req_i.re_b) begin
      rd_b_q <= mem[req_i.addr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== sv/tile_background_pixel_fetch.sv =====
// Channel  Direction  Signals                               Beat type
// in       input      in_valid_i, in_stall_o, in_beat_i     in_beat_t
// out      output     out_valid_o, out_stall_i, out_beat_o  out_beat_t
// cfg      input      cfg_we_i, cfg_index_i, cfg_wdata_i    -
//
// A write beat is done in the cycle it is taken; a fetch beat takes three steps:
// a map read, a two-port read of both bit-plane bytes, then the output register
// load, held while the output stalls; the dependent reads set these steps.
// Reset returns the control state and the configuration registers only to their
// reset values; video memory holds no defined contents until written.
// A stalled output register holds its beat while the next input beat is taken.
`default_nettype none

module tile_background_pixel_fetch
  import tbpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_beat_t          in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_beat_t              out_beat_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_index_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i
);

  state_e     state_q, state_d;
  logic       map_sel_q;
  logic       data_sel_q;
  logic [7:0] palette_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_beat_q, out_beat_d;
  vram_req_t  req;
  logic [7:0] rd_a;
  logic [7:0] rd_b;
  logic       in_acc;
  logic [8:0] tile_idx;
  logic [VRAM_AW-1:0] row_lo;
  logic [VRAM_AW-1:0] row_hi;
  logic [1:0] ci;
  logic [2:0] bit_sel;

  tbpf_vram u_vram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel_q  <= MAP_SELECT_RST;
      data_sel_q <= DATA_SELECT_RST;
      palette_q  <= PALETTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_SELECT:  map_sel_q  <= cfg_wdata_i[0];
        CFG_DATA_SELECT: data_sel_q <= cfg_wdata_i[0];
        CFG_PALETTE:     palette_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_beat_i.pixel_x;
      y_q <= in_beat_i.pixel_y;
    end
    out_beat_q <= out_beat_d;
  end

  // Tiles are 16 bytes, so the row address is the tile index with the row
  // number and plane bit appended.
  assign tile_idx = data_sel_q ? {1'b0, rd_a} : SIGNED_TILE_BASE + {rd_a[7], rd_a};
  assign row_lo   = {tile_idx, y_q[2:0], 1'b0};
  assign row_hi   = {tile_idx, y_q[2:0], 1'b1};

  assign bit_sel = ~x_q[2:0];
  assign ci      = {rd_b[bit_sel], rd_a[bit_sel]};

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_beat_d  = out_beat_q;
    req         = '0;
    req.waddr   = in_beat_i.mem_offset;
    req.wdata   = in_beat_i.mem_byte;
    req.addr_a  = {MAP_AREA_TOP, map_sel_q, in_beat_i.pixel_y[7:3], in_beat_i.pixel_x[7:3]};
    req.addr_b  = row_hi;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_beat_i.kind == KIND_WRITE) begin
            req.we = 1'b1;
          end else begin
            req.re_a = 1'b1;
            state_d  = S_MAP;
          end
        end
      end
      S_MAP: begin
        req.addr_a = row_lo;
        req.re_a   = 1'b1;
        req.re_b   = 1'b1;
        state_d    = S_ROW;
      end
      S_ROW: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_beat_d.out_x       = x_q;
          out_beat_d.out_y       = y_q;
          out_beat_d.color_index = ci;
          out_beat_d.shade       = palette_q[{ci, 1'b0} +: 2];
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_fetch_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.kind == KIND_FETCH) |=> (state_q == S_MAP) ##1 (state_q == S_ROW))
    else $error("fetch did not walk map and row reads");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (state_q == S_IDLE) && in_valid_i && !req.re_a)
    else $error("video memory write outside an accepted write beat");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_ROW))
    else $error("result appeared without a completed fetch");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW) && out_valid_q && out_stall_i |=> (state_q == S_ROW) && out_valid_q)
    else $error("fetch left row state while the output was blocked");

endmodule

`default_nettype wire
